[sv/sha_pkg.sv]
`default_nettype none
package sha_pkg;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // One 32-bit schedule word handed from front to back
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;  // 16th word of a block
    logic        msg_end;  // last word of the message
  } sha_word_t;

  typedef enum logic [1:0] {
    FE_ACCEPT,
    FE_PAD,
    FE_LEN_HI,
    FE_LEN_LO
  } fe_state_e;

  typedef enum logic [1:0] {
    BE_LOAD,
    BE_ROUND,
    BE_FOLD,
    BE_EMIT
  } be_state_e;

endpackage
`default_nettype wire

[sv/sha_front.sv]
`default_nettype none
// Pack bytes into words, track length and insert the padding
module sha_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [7:0]             data_byte_i,
  input  wire                    has_byte_i,
  input  wire                    is_last_i,
  output logic                   wr_en_o,
  output sha_pkg::sha_word_t     wr_data_o,
  input  wire                    full_i
);
  import sha_pkg::*;

  fe_state_e   state_q, state_d;
  logic [63:0] len_q, len_d;
  logic [5:0]  fill_q, fill_d;
  logic [23:0] acc_q, acc_d;
  logic        pad_first_q, pad_first_d;
  logic        go_word;
  logic [7:0]  byte_in;
  logic [31:0] word_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FE_ACCEPT;
      len_q       <= '0;
      fill_q      <= '0;
      pad_first_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      pad_first_q <= pad_first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    fill_d      = fill_q;
    acc_d       = acc_q;
    pad_first_d = pad_first_q;
    in_stall_o  = 1'b1;
    wr_en_o     = 1'b0;
    byte_in     = data_byte_i;
    go_word     = 1'b0;
    word_out    = {acc_q, byte_in};
    wr_data_o   = '{word: word_out, blk_end: fill_q == 6'd63, msg_end: 1'b0};
    case (state_q)
      FE_ACCEPT: begin
        // a byte that closes a word must have queue room
        in_stall_o = full_i && has_byte_i && (fill_q[1:0] == 2'd3);
        if (in_valid_i && !in_stall_o) begin
          if (has_byte_i) begin
            len_d   = len_q + 64'd8;
            go_word = 1'b1;
          end else if (is_last_i) begin
            state_d = FE_PAD;
          end
          if (has_byte_i && is_last_i) state_d = FE_PAD;
          if (is_last_i) pad_first_d = 1'b1;
        end
      end
      FE_PAD: begin
        // 0x80 first, then zeros; 56 mod 64 hands over to the length
        byte_in = pad_first_q ? PAD_BYTE : 8'h00;
        if (fill_q == 6'd56 && !pad_first_q) begin
          state_d = FE_LEN_HI;
        end else if (!(fill_q[1:0] == 2'd3 && full_i)) begin
          go_word     = 1'b1;
          pad_first_d = 1'b0;
        end
      end
      FE_LEN_HI: begin
        wr_en_o   = !full_i;
        wr_data_o = '{word: len_q[63:32], blk_end: 1'b0, msg_end: 1'b0};
        if (!full_i) begin
          state_d = FE_LEN_LO;
          fill_d  = 6'd60;
        end
      end
      FE_LEN_LO: begin
        wr_en_o   = !full_i;
        wr_data_o = '{word: len_q[31:0], blk_end: 1'b1, msg_end: 1'b1};
        if (!full_i) begin
          state_d = FE_ACCEPT;
          fill_d  = '0;
          len_d   = '0;
        end
      end
      default: state_d = FE_ACCEPT;
    endcase
    if (go_word) begin
      word_out = {acc_q, byte_in};
      wr_data_o = '{word: word_out, blk_end: fill_q == 6'd63, msg_end: 1'b0};
      fill_d   = fill_q + 6'd1;
      acc_d    = {acc_q[15:0], byte_in};
      wr_en_o  = (fill_q[1:0] == 2'd3);
    end
  end
  // pad marker: first pad byte follows the message; tracked by pad_first_q
endmodule
`default_nettype wire

[sv/sha_fifo.sv]
`default_nettype none
// Short word queue between front and back
module sha_fifo #(
  parameter int Depth = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 wr_en_i,
  input  sha_pkg::sha_word_t  wr_data_i,
  output logic                full_o,
  input  wire                 rd_en_i,
  output sha_pkg::sha_word_t  rd_data_o,
  output logic                empty_o
);
  import sha_pkg::*;
  localparam int AW = $clog2(Depth);

  sha_word_t       mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o    = cnt_q == (AW+1)'(Depth);
  assign empty_o   = cnt_q == '0;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en_i) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + AW'(1);
      if (rd_en_i) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr_en_i) - (AW+1)'(rd_en_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

[sv/sha_back.sv]
`default_nettype none
// Schedule, 64 rounds, fold into hash and emit digest
module sha_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 empty_i,
  input  sha_pkg::sha_word_t  rd_data_i,
  output logic                rd_en_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o
);
  import sha_pkg::*;

  be_state_e   state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  t_q;
  logic [2:0]  idx_q;
  logic        fin_q;
  logic        take;
  logic [31:0] w_new, x2, x15, s0, s1, t1, t2, e, a;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    x2  = w_q[14];
    x15 = w_q[1];
    s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    w_new = (t_q < 6'd16) ? rd_data_i.word : s1 + w_q[9] + s0 + w_q[0];
    e  = v_q[4];
    a  = v_q[0];
    t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[t_q] + w_new;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    state_d     = state_q;
    take        = 1'b0;
    rd_en_o     = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BE_LOAD:  state_d = BE_ROUND;
      BE_ROUND: begin
        take    = (t_q >= 6'd16) || !empty_i;
        rd_en_o = (t_q < 6'd16) && !empty_i;
        if (take && t_q == 6'd63) state_d = BE_FOLD;
      end
      BE_FOLD:  state_d = fin_q ? BE_EMIT : BE_LOAD;
      BE_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i && idx_q == 3'd7) state_d = BE_LOAD;
      end
      default:  state_d = BE_LOAD;
    endcase
  end

  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = idx_q == 3'd7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_LOAD;
      t_q     <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      state_q <= state_d;
      case (state_q)
        BE_LOAD: begin
          t_q <= '0;
          idx_q <= '0;
        end
        BE_ROUND: begin
          if (take) begin
            t_q <= t_q + 6'd1;
            if (rd_en_o && rd_data_i.blk_end) fin_q <= rd_data_i.msg_end;
          end
        end
        BE_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        BE_EMIT: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              fin_q <= 1'b0;
              for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (state_q == BE_LOAD) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == BE_ROUND && take) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire

[sv/sha256_hash_core.sv]
`default_nettype none
// Channel | Valid / stall        | Payload
// request | in_valid_i/in_stall_o | data_byte_i, has_byte_i, is_last_i
// digest  | out_valid_o/out_stall_i | digest_word_o, word_index_o, last_word_o
//
// A valid byte is taken while in_stall_o is low; every fourth byte pushes a word into a
// four-entry queue. The back end handles a block as load, 64 rounds and
// fold, and it reads the first sixteen words only as fast as the front
// packs them. The last request adds padding at one byte a cycle while the
// queue has room, then eight digest words follow. Reset restores the initial
// hash; stalls hold each side.
module sha256_hash_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         has_byte_i,
  input  wire         is_last_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  logic      wr_en, full, rd_en, empty;
  sha_word_t wr_data, rd_data;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .has_byte_i,
    .is_last_i, .wr_en_o(wr_en), .wr_data_o(wr_data), .full_i(full));

  sha_fifo #(.Depth(4)) u_fifo (
    .clk_i, .rst_ni, .wr_en_i(wr_en), .wr_data_i(wr_data), .full_o(full),
    .rd_en_i(rd_en), .rd_data_o(rd_data), .empty_o(empty));

  sha_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .rd_data_i(rd_data), .rd_en_o(rd_en),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && empty)) else $error("queue underflow");
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
    out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest index skipped");
endmodule
`default_nettype wire
